/* src/uer_pkg.sv */
package uer_pkg;

  // Widths of the stream fields and configuration registers
  localparam int TIMER_IN_W   = 16;
  localparam int DIST_W       = 15;
  localparam int MAX_DIST_W   = 14;
  localparam int LIMIT_W      = 16;
  localparam int WAIT_W       = 17;
  localparam int CFG_DATA_W   = 16;
  localparam int S_TDATA_W    = 24;
  localparam int M_TDATA_W    = 24;

  localparam int TIMER_BITS_DEFAULT = 16;

  // Register indexes of the configuration channel
  localparam logic CFG_TIMEOUT_LIMIT = 1'b0;
  localparam logic CFG_MAX_DISTANCE  = 1'b1;

  localparam logic [LIMIT_W-1:0]    TIMEOUT_LIMIT_RESET = 16'd50000;
  localparam logic [MAX_DIST_W-1:0] MAX_DISTANCE_RESET  = 14'd4000;

  // Distance marked invalid or pending
  localparam logic [DIST_W-1:0] DIST_INVALID = '1;
  localparam logic [WAIT_W-1:0] WAIT_MAX     = '1;

  // mm = us * 170 / 1000 = (us * 17) / 100.
  // us * 17 stays below 2^21; /100 is a multiply by ceil(2^27/100) and a shift,
  // exact for every product below 2^27/72.
  localparam int SCALED_W  = 21;
  localparam int DIV_SHIFT = 27;
  localparam logic [SCALED_W-1:0] DIV_MULT = 21'd1342178;

  // Input kinds carried in s_axis_tuser
  localparam logic OP_POLL    = 1'b0;
  localparam logic OP_TRIGGER = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_TRIG    = 2'd1,
    PH_HIGH    = 2'd2,
    PH_TIMEOUT = 2'd3
  } phase_t;

endpackage

/* src/ultrasonic_echo_ranger.sv */
// Channel    Direction  Handshake              Payload
// s_axis     in         s_axis_tvalid/tready   tuser: op; tdata: echo_level, timer_count
// m_axis     out        m_axis_tvalid/tready   tdata: ranger_state, distance, trigger_pulse
// cfg        in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One beat in gives one beat out; the block takes a beat in every cycle unless a full output
// register is stalled. The result of a beat is computed in the accepting cycle and is loaded
// into the output register at the end of that cycle; the distance path (subtract, constant multiply, compare)
// sets the clock period.
// s_axis_tready stays high while the output register is empty or being drained, so a
// stalled output holds exactly one finished beat and blocks input only then.
// rst (synchronous) returns the ranger to idle, distance to invalid and the
// registers to timeout_limit 50000, max_distance 4000; cfg_ready is always high.
module ultrasonic_echo_ranger #(
  parameter int TIMER_BITS = uer_pkg::TIMER_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // Input beat
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [uer_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [0] echo_level, [16:1] timer_count, [23:17] zero
  input  logic                          s_axis_tuser,  // [0] op: 0 poll tick, 1 trigger
  // Result beat
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [uer_pkg::M_TDATA_W-1:0] m_axis_tdata,  // [1:0] ranger_state, [16:2] distance,
                                                       // [17] trigger_pulse, [23:18] zero
  // Configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_data
);
  import uer_pkg::*;

  // Only the low bits of the 16-bit timer field that the timer really has are used
  localparam int STAMP_W = (TIMER_BITS < TIMER_IN_W) ? TIMER_BITS : TIMER_IN_W;

  // Configuration registers
  logic [LIMIT_W-1:0]    timeout_limit;
  logic [MAX_DIST_W-1:0] max_distance;

  // Ranger state
  phase_t               phase;
  phase_t               phase_next;
  logic [STAMP_W-1:0]   start_stamp;
  logic [STAMP_W-1:0]   start_stamp_next;
  logic [WAIT_W-1:0]    wait_count;
  logic [WAIT_W-1:0]    wait_count_next;
  logic [DIST_W-1:0]    last_distance;
  logic [DIST_W-1:0]    last_distance_next;
  logic                 pulse_next;

  // Output register
  logic                 out_valid;
  logic [1:0]           out_state;
  logic [DIST_W-1:0]    out_distance;
  logic                 out_pulse;

  // Input fields
  logic                 in_accept;
  logic                 op;
  logic                 echo_level;
  logic [TIMER_IN_W-1:0] timer_count;
  logic [STAMP_W-1:0]   now;

  // Distance datapath
  logic                   in_order;
  logic [STAMP_W-1:0]     duration;
  logic [TIMER_IN_W-1:0]  duration_us;
  logic [SCALED_W-1:0]    scaled;
  logic [2*SCALED_W-1:0]  product;
  logic [MAX_DIST_W-1:0]  mm;
  logic [DIST_W-1:0]      measured;

  // Wait counter
  logic [WAIT_W-1:0]    wait_inc;
  logic                 wait_over;

  assign in_accept   = s_axis_tvalid & s_axis_tready;
  assign op          = s_axis_tuser;
  assign echo_level  = s_axis_tdata[0];
  assign timer_count = s_axis_tdata[TIMER_IN_W:1];
  assign now         = timer_count[STAMP_W-1:0];

  // Take a new beat whenever the output register is free or drains this cycle
  assign s_axis_tready = ~out_valid | m_axis_tready;
  assign cfg_ready     = 1'b1;

  // Echo pulse width in microseconds; a wrapped timer gives no distance
  assign in_order    = (now >= start_stamp);
  assign duration    = now - start_stamp;
  assign duration_us = TIMER_IN_W'(duration);
  // us * 17 as shift and add, then divide by 100 through the reciprocal
  assign scaled      = {duration_us, 4'b0000} + SCALED_W'(duration_us);
  assign product     = scaled * DIV_MULT;
  assign mm          = product[DIV_SHIFT +: MAX_DIST_W];
  assign measured    = (in_order && (mm <= max_distance)) ? DIST_W'(mm) : DIST_INVALID;

  // Saturate the wait counter; declare timeout once it passes the limit
  assign wait_inc  = (wait_count < WAIT_MAX) ? wait_count + WAIT_W'(1) : wait_count;
  assign wait_over = (wait_inc > WAIT_W'(timeout_limit));

  // Next phase
  always_comb begin
    phase_next = phase;
    if (op == OP_TRIGGER) begin
      if (phase == PH_IDLE) begin
        phase_next = PH_TRIG;
      end
    end else begin
      unique case (phase)
        PH_IDLE: begin
          phase_next = PH_IDLE;
        end
        PH_TRIG: begin
          if (echo_level) begin
            phase_next = PH_HIGH;
          end else if (wait_over) begin
            phase_next = PH_TIMEOUT;
          end
        end
        PH_HIGH: begin
          if (!echo_level) begin
            phase_next = PH_IDLE;
          end else if (wait_over) begin
            phase_next = PH_TIMEOUT;
          end
        end
        PH_TIMEOUT: begin
          phase_next = PH_IDLE;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // Datapath updates that go with each phase
  always_comb begin
    start_stamp_next   = start_stamp;
    wait_count_next    = wait_count;
    last_distance_next = last_distance;
    pulse_next         = 1'b0;
    if (op == OP_TRIGGER) begin
      if (phase == PH_IDLE) begin
        pulse_next         = 1'b1;
        wait_count_next    = '0;
        last_distance_next = DIST_INVALID;
      end
    end else begin
      unique case (phase)
        PH_IDLE: begin
          pulse_next = 1'b0;
        end
        PH_TRIG: begin
          if (echo_level) begin
            start_stamp_next = now;
            wait_count_next  = '0;
          end else begin
            wait_count_next = wait_inc;
          end
        end
        PH_HIGH: begin
          if (!echo_level) begin
            last_distance_next = measured;
          end else begin
            wait_count_next = wait_inc;
          end
        end
        PH_TIMEOUT: begin
          last_distance_next = DIST_INVALID;
        end
        default: begin
          pulse_next = 1'b0;
        end
      endcase
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= TIMEOUT_LIMIT_RESET;
      max_distance  <= MAX_DISTANCE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TIMEOUT_LIMIT: timeout_limit <= cfg_data[LIMIT_W-1:0];
        CFG_MAX_DISTANCE:  max_distance  <= cfg_data[MAX_DIST_W-1:0];
        default:           timeout_limit <= timeout_limit;
      endcase
    end
  end

  // Ranger state advances on every accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      start_stamp   <= '0;
      wait_count    <= '0;
      last_distance <= DIST_INVALID;
    end else if (in_accept) begin
      phase         <= phase_next;
      start_stamp   <= start_stamp_next;
      wait_count    <= wait_count_next;
      last_distance <= last_distance_next;
    end
  end

  // Output register: load on accept, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_state    <= phase_next;
      out_distance <= last_distance_next;
      out_pulse    <= pulse_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = M_TDATA_W'({out_pulse, out_distance, out_state});

  // A trigger pulse only ever leaves with the triggered state and an invalid distance
  a_pulse_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_pulse) |-> (out_state == PH_TRIG && out_distance == DIST_INVALID))
    else $error("trigger pulse without triggered state");

  // While a measurement is open the distance reads as invalid
  a_busy_invalid: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE) |-> (last_distance == DIST_INVALID))
    else $error("distance valid while busy");

  // The output register mirrors the state it was loaded with
  a_out_tracks_state: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (out_valid && out_state == phase && out_distance == last_distance))
    else $error("output beat does not match ranger state");

  // A freshly measured distance never exceeds the configured maximum
  a_dist_bound: assert property (@(posedge clk) disable iff (rst)
    (measured != DIST_INVALID) |-> (measured <= DIST_W'(max_distance)))
    else $error("distance above maximum");

endmodule
